// File: sv/cbbc_pkg.sv
// Package for the C source bracket balance checker.
// Holds result types, scan mode and kind codes, and character constants.
// No dependencies.
package cbbc_pkg;

    localparam int KIND_W  = 3;
    localparam int LINE_W  = 24;
    localparam int CHAR_W  = 8;
    localparam int CNT_W   = 16;

    // Result queue geometry: room for two end items in flight.
    localparam int MAX_RESULTS = 3;
    localparam int RQ_DEPTH    = 8;
    localparam int RQ_AW       = 3;
    localparam int RQ_CW       = 4;

    typedef enum logic [KIND_W-1:0] {
        KIND_CLOSE    = 3'd0,
        KIND_BRACES   = 3'd1,
        KIND_BRACKETS = 3'd2,
        KIND_PARENS   = 3'd3,
        KIND_BALANCED = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        MODE_CODE    = 2'd0,
        MODE_SLASH   = 2'd1,
        MODE_COMMENT = 2'd2,
        MODE_STAR    = 2'd3
    } t_scan_mode;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_END  = 1'b1;

    localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
    localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
    localparam logic [CHAR_W-1:0] CH_LBRACK = 8'h5B;
    localparam logic [CHAR_W-1:0] CH_RBRACK = 8'h5D;
    localparam logic [CHAR_W-1:0] CH_LBRACE = 8'h7B;
    localparam logic [CHAR_W-1:0] CH_RBRACE = 8'h7D;
    localparam logic [CHAR_W-1:0] CH_BSLASH = 8'h5C;
    localparam logic [CHAR_W-1:0] CH_LF     = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_DQUOTE = 8'h22;
    localparam logic [CHAR_W-1:0] CH_SQUOTE = 8'h27;
    localparam logic [CHAR_W-1:0] CH_SLASH  = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_STAR   = 8'h2A;

    typedef struct packed {
        t_kind              kind;
        logic [LINE_W-1:0]  line_number;
        logic [CHAR_W-1:0]  close_char;
        logic [CNT_W-1:0]   open_count;
        logic               last;
    } t_result;

    // Results produced by one item, all written into the queue in the same cycle.
    typedef struct packed {
        logic [1:0]                    num;
        t_result [MAX_RESULTS-1:0]     res;
    } t_push;

endpackage

// File: sv/cbbc_ifs.sv
// Valid/ready channel interfaces for the bracket balance checker.
// Depends on cbbc_pkg for field widths.
interface cbbc_in_if;
    logic                       valid;
    logic                       ready;
    logic                       op;
    logic [cbbc_pkg::CHAR_W-1:0] text_byte;

    modport source (output valid, output op, output text_byte, input ready);
    modport sink   (input valid, input op, input text_byte, output ready);
endinterface

interface cbbc_out_if;
    logic                        valid;
    logic                        ready;
    logic [cbbc_pkg::KIND_W-1:0] kind;
    logic [cbbc_pkg::LINE_W-1:0] line_number;
    logic [cbbc_pkg::CHAR_W-1:0] close_char;
    logic [cbbc_pkg::CNT_W-1:0]  open_count;
    logic                        last;

    modport source (output valid, output kind, output line_number, output close_char,
                    output open_count, output last, input ready);
    modport sink   (input valid, input kind, input line_number, input close_char,
                    input open_count, input last, output ready);
endinterface

// File: sv/cbbc_scan.sv
// Scanner: input register, lexical state and bracket counters.
// Produces up to three result beats per item. Depends on cbbc_pkg.
module cbbc_scan #(
    parameter int LINE_BITS  = 24,
    parameter int COUNT_BITS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  logic                           i_op,
    input  logic [cbbc_pkg::CHAR_W-1:0]    i_byte,
    input  logic [cbbc_pkg::RQ_CW-1:0]     i_level,
    output logic                           o_ready,
    output cbbc_pkg::t_push                o_push
);
    import cbbc_pkg::*;

    localparam logic [RQ_CW-1:0] RESERVE    = RQ_CW'(MAX_RESULTS);
    localparam logic [RQ_CW-1:0] ACCEPT_MAX = RQ_CW'(RQ_DEPTH - MAX_RESULTS);

    logic                   r_in_vld;
    logic                   r_op;
    logic [CHAR_W-1:0]      r_byte;

    t_scan_mode             r_mode, n_mode;
    logic                   r_in_quote, n_in_quote;
    logic                   r_quote_single, n_quote_single;
    logic                   r_skip, n_skip;
    logic [LINE_BITS-1:0]   r_line, n_line;
    logic [COUNT_BITS-1:0]  r_paren, n_paren;
    logic [COUNT_BITS-1:0]  r_bracket, n_bracket;
    logic [COUNT_BITS-1:0]  r_brace, n_brace;

    logic                   code_go;
    logic                   q_now;
    logic                   is_single;
    logic                   bad;
    logic [1:0]             idx;
    logic [LINE_BITS+LINE_W-1:0]  line_ext;
    logic [COUNT_BITS+CNT_W-1:0]  brace_ext, bracket_ext, paren_ext;

    // Leave room in the queue for the beat in flight plus this one.
    assign o_ready = ((i_level + (r_in_vld ? RESERVE : '0)) <= ACCEPT_MAX);

    assign line_ext    = {{LINE_W{1'b0}}, n_line};
    assign brace_ext   = {{CNT_W{1'b0}}, r_brace};
    assign bracket_ext = {{CNT_W{1'b0}}, r_bracket};
    assign paren_ext   = {{CNT_W{1'b0}}, r_paren};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= i_valid && o_ready;
        end
        if (i_valid && o_ready) begin
            r_op   <= i_op;
            r_byte <= i_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode         <= MODE_CODE;
            r_in_quote     <= 1'b0;
            r_quote_single <= 1'b0;
            r_skip         <= 1'b0;
            r_line         <= LINE_BITS'(1);
            r_paren        <= '0;
            r_bracket      <= '0;
            r_brace        <= '0;
        end else begin
            r_mode         <= n_mode;
            r_in_quote     <= n_in_quote;
            r_quote_single <= n_quote_single;
            r_skip         <= n_skip;
            r_line         <= n_line;
            r_paren        <= n_paren;
            r_bracket      <= n_bracket;
            r_brace        <= n_brace;
        end
    end

    always_comb begin
        n_mode         = r_mode;
        n_in_quote     = r_in_quote;
        n_quote_single = r_quote_single;
        n_skip         = r_skip;
        n_line         = r_line;
        n_paren        = r_paren;
        n_bracket      = r_bracket;
        n_brace        = r_brace;
        code_go        = 1'b0;
        q_now          = r_in_quote;
        is_single      = (r_byte == CH_SQUOTE);
        bad            = 1'b0;
        idx            = '0;
        o_push         = '0;

        if (r_in_vld) begin
            if (r_op == OP_END) begin
                if (r_brace != '0) begin
                    o_push.res[idx].kind       = KIND_BRACES;
                    o_push.res[idx].open_count = brace_ext[CNT_W-1:0];
                    idx = idx + 2'd1;
                end
                if (r_bracket != '0) begin
                    o_push.res[idx].kind       = KIND_BRACKETS;
                    o_push.res[idx].open_count = bracket_ext[CNT_W-1:0];
                    idx = idx + 2'd1;
                end
                if (r_paren != '0) begin
                    o_push.res[idx].kind       = KIND_PARENS;
                    o_push.res[idx].open_count = paren_ext[CNT_W-1:0];
                    idx = idx + 2'd1;
                end
                if (idx == 2'd0) begin
                    o_push.res[0].kind = KIND_BALANCED;
                    o_push.res[0].last = 1'b1;
                    o_push.num         = 2'd1;
                end else begin
                    o_push.res[idx - 2'd1].last = 1'b1;
                    o_push.num                  = idx;
                end
                n_mode         = MODE_CODE;
                n_in_quote     = 1'b0;
                n_quote_single = 1'b0;
                n_skip         = 1'b0;
                n_line         = LINE_BITS'(1);
                n_paren        = '0;
                n_bracket      = '0;
                n_brace        = '0;
            end else if (r_skip) begin
                n_skip = 1'b0;
            end else begin
                if (r_byte == CH_LF && r_line != {LINE_BITS{1'b1}}) begin
                    n_line = r_line + LINE_BITS'(1);
                end
                if (r_mode == MODE_COMMENT || r_mode == MODE_STAR) begin
                    if (r_mode == MODE_STAR && r_byte == CH_SLASH) begin
                        n_mode = MODE_CODE;
                    end else begin
                        n_mode = (r_byte == CH_STAR) ? MODE_STAR : MODE_COMMENT;
                    end
                end else begin
                    code_go = 1'b1;
                    if (r_mode == MODE_SLASH) begin
                        n_mode = MODE_CODE;
                        if (r_byte == CH_STAR) begin
                            n_mode  = MODE_COMMENT;
                            code_go = 1'b0;
                        end
                    end
                end

                if (code_go) begin
                    if (r_byte == CH_BSLASH) begin
                        n_skip = 1'b1;
                    end else begin
                        if (r_byte == CH_DQUOTE || r_byte == CH_SQUOTE) begin
                            if (!r_in_quote) begin
                                q_now          = 1'b1;
                                n_quote_single = is_single;
                            end else if (is_single == r_quote_single) begin
                                q_now = 1'b0;
                            end
                        end
                        n_in_quote = q_now;
                        if (!q_now) begin
                            case (r_byte)
                                CH_SLASH: n_mode = MODE_SLASH;
                                CH_LPAREN: begin
                                    if (r_paren != {COUNT_BITS{1'b1}})
                                        n_paren = r_paren + COUNT_BITS'(1);
                                end
                                CH_LBRACK: begin
                                    if (r_bracket != {COUNT_BITS{1'b1}})
                                        n_bracket = r_bracket + COUNT_BITS'(1);
                                end
                                CH_LBRACE: begin
                                    if (r_brace != {COUNT_BITS{1'b1}})
                                        n_brace = r_brace + COUNT_BITS'(1);
                                end
                                CH_RBRACE: begin
                                    if (r_brace == '0) bad = 1'b1;
                                    else n_brace = r_brace - COUNT_BITS'(1);
                                end
                                CH_RBRACK: begin
                                    if (r_bracket == '0) bad = 1'b1;
                                    else n_bracket = r_bracket - COUNT_BITS'(1);
                                end
                                CH_RPAREN: begin
                                    if (r_paren == '0) bad = 1'b1;
                                    else n_paren = r_paren - COUNT_BITS'(1);
                                end
                                default: ;
                            endcase
                        end
                    end
                end

                if (bad) begin
                    o_push.num                 = 2'd1;
                    o_push.res[0].kind         = KIND_CLOSE;
                    o_push.res[0].line_number  = line_ext[LINE_W-1:0];
                    o_push.res[0].close_char   = r_byte;
                    o_push.res[0].last         = 1'b1;
                end
            end
        end
    end

endmodule

// File: sv/cbbc_resq.sv
// Result queue: eight-entry FIFO of result beats, up to three written per cycle.
// Depends on cbbc_pkg.
module cbbc_resq (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  cbbc_pkg::t_push             i_push,
    input  logic                        i_ready,
    output logic                        o_valid,
    output cbbc_pkg::t_result           o_data,
    output logic [cbbc_pkg::RQ_CW-1:0]  o_level
);
    import cbbc_pkg::*;

    t_result            r_q [RQ_DEPTH];
    logic [RQ_AW-1:0]   r_wp;
    logic [RQ_AW-1:0]   r_rp;
    logic [RQ_CW-1:0]   r_cnt;
    logic               pop;

    assign o_valid = (r_cnt != '0);
    assign o_data  = r_q[r_rp];
    assign o_level = r_cnt;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + RQ_AW'(i_push.num);
            r_rp  <= r_rp + RQ_AW'(pop);
            r_cnt <= r_cnt + RQ_CW'(i_push.num) - RQ_CW'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < MAX_RESULTS; i++) begin
            if (i < int'(i_push.num)) begin
                r_q[r_wp + RQ_AW'(i)] <= i_push.res[i];
            end
        end
    end

endmodule

// File: sv/c_source_bracket_balance_checker.sv
// C source bracket balance checker, top level.
// Depends on cbbc_pkg, cbbc_ifs, cbbc_scan and cbbc_resq.
//
// Takes one beat per cycle while input ready is high: op 0 carries a
// source byte, op 1 marks end of text. A byte yields no result or one
// unbalanced-close report; an end beat yields one to three reports (braces,
// brackets, parens, or one balanced marker), the final one flagged by last,
// and then clears all state. A result passes through the input register
// and is then written to the eight-entry result queue. Input ready drops
// only when that queue lacks room for the reports of the beat in the input
// register plus one more end beat, so a waiting output does not stall the
// input until the queue fills.
module c_source_bracket_balance_checker #(
    parameter int LINE_BITS  = 24,
    parameter int COUNT_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    cbbc_in_if.sink      i_in,
    cbbc_out_if.source   o_out
);
    import cbbc_pkg::*;

    t_push              push;
    t_result            q_data;
    logic [RQ_CW-1:0]   q_level;

    cbbc_scan #(
        .LINE_BITS  (LINE_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .i_op    (i_in.op),
        .i_byte  (i_in.text_byte),
        .i_level (q_level),
        .o_ready (i_in.ready),
        .o_push  (push)
    );

    cbbc_resq u_resq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_ready (o_out.ready),
        .o_valid (o_out.valid),
        .o_data  (q_data),
        .o_level (q_level)
    );

    assign o_out.kind        = q_data.kind;
    assign o_out.line_number = q_data.line_number;
    assign o_out.close_char  = q_data.close_char;
    assign o_out.open_count  = q_data.open_count;
    assign o_out.last        = q_data.last;

endmodule
